/* sv/pp2rgba_pkg.sv */
package pp2rgba_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned CHAN_W = 8;
    localparam int unsigned FMT_W  = 4;
    localparam int unsigned OUT_W  = 40;

    localparam logic [FMT_W-1:0] FMT_RGB888      = 4'd0;
    localparam logic [FMT_W-1:0] FMT_ARGB8888    = 4'd1;
    localparam logic [FMT_W-1:0] FMT_XRGB8888    = 4'd2;
    localparam logic [FMT_W-1:0] FMT_ABGR8888    = 4'd3;
    localparam logic [FMT_W-1:0] FMT_XBGR8888    = 4'd4;
    localparam logic [FMT_W-1:0] FMT_RGB565      = 4'd5;
    localparam logic [FMT_W-1:0] FMT_ARGB1555    = 4'd6;
    localparam logic [FMT_W-1:0] FMT_XRGB1555    = 4'd7;
    localparam logic [FMT_W-1:0] FMT_ARGB4444    = 4'd8;
    localparam logic [FMT_W-1:0] FMT_XRGB4444    = 4'd9;
    localparam logic [FMT_W-1:0] FMT_RGB332      = 4'd10;
    localparam logic [FMT_W-1:0] FMT_ARGB8332    = 4'd11;
    localparam logic [FMT_W-1:0] FMT_ARGB2101010 = 4'd12;

    localparam logic [FMT_W-1:0] FMT_RESET = FMT_ARGB8888;

    localparam logic [CHAN_W-1:0] CHAN_FULL = 8'hFF;

    typedef struct packed {
        logic [6:0]        pad;
        logic              valid_res;
        logic [CHAN_W-1:0] alpha;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } t_rgba;

    // 3-bit channel scaled as v*255/7, truncated
    function automatic logic [CHAN_W-1:0] widen3(input logic [2:0] v);
        logic [CHAN_W-1:0] res;
        case (v)
            3'd0:    res = 8'd0;
            3'd1:    res = 8'd36;
            3'd2:    res = 8'd72;
            3'd3:    res = 8'd109;
            3'd4:    res = 8'd145;
            3'd5:    res = 8'd182;
            3'd6:    res = 8'd218;
            default: res = 8'd255;
        endcase
        return res;
    endfunction

endpackage

/* sv/packed_pixel_to_rgba8.sv */
// An accepted beat moves from the input register to the result register, then on m_axis.
// One beat per cycle unless m_axis stalls; input register, unpack logic, result register.
// A stalled result holds in the result register while one more beat waits in the input one.
// Reset (synchronous, active low) empties both stages and sets the format to ARGB8888.
module packed_pixel_to_rgba8 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [3:0]  i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // pixel_word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // red, green, blue, alpha, valid_res, zero pad
);

    logic [pp2rgba_pkg::FMT_W-1:0]  r_fmt;
    logic                           s1_valid;
    logic                           s1_ready;
    logic [pp2rgba_pkg::WORD_W-1:0] s1_word;
    pp2rgba_pkg::t_rgba             unpacked;
    pp2rgba_pkg::t_rgba             res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= pp2rgba_pkg::FMT_RESET;
        end else if (i_cfg_wr_en) begin
            r_fmt <= i_cfg_wr_data;
        end
    end

    pp2rgba_stage #(.W(pp2rgba_pkg::WORD_W)) u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .o_valid (s1_valid),
        .i_ready (s1_ready),
        .o_data  (s1_word)
    );

    pp2rgba_unpack u_unpack (
        .i_fmt  (r_fmt),
        .i_word (s1_word),
        .o_res  (unpacked)
    );

    pp2rgba_stage #(.W(pp2rgba_pkg::OUT_W)) u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_data  (unpacked),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (res)
    );

    assign m_axis_tdata = res;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("pipeline not empty after reset");

    a_unsupported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[32] |-> m_axis_tdata[31:0] == 32'hFF00_0000)
        else $error("unsupported format result not 0,0,0,255");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_valid && m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while both stages full");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[39:33] == 7'd0)
        else $error("result pad bits not zero");

endmodule

/* sv/pp2rgba_stage.sv */
module pp2rgba_stage #(
    parameter int unsigned W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-1:0] o_data
);

    logic         r_valid;
    logic [W-1:0] r_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

endmodule

/* sv/pp2rgba_unpack.sv */
module pp2rgba_unpack (
    input  logic [pp2rgba_pkg::FMT_W-1:0]  i_fmt,
    input  logic [pp2rgba_pkg::WORD_W-1:0] i_word,
    output pp2rgba_pkg::t_rgba             o_res
);

    logic [7:0]  b0, b1, b2, b3;
    logic [15:0] h;
    logic [7:0]  r, g, b, a;
    logic        ok;
    logic [7:0]  w10_r, w10_g, w10_b;

    assign b0 = i_word[7:0];
    assign b1 = i_word[15:8];
    assign b2 = i_word[23:16];
    assign b3 = i_word[31:24];
    assign h  = i_word[15:0];

    // (v*255 + 511) / 1023 by reciprocal estimate and one correction step
    function automatic logic [7:0] widen10(input logic [9:0] v);
        logic [17:0] x;
        logic [18:0] est;
        logic [7:0]  q0;
        logic [17:0] rem;
        logic [7:0]  q;
        x   = ({8'd0, v} << 8) - {8'd0, v} + 18'd511;
        est = {1'b0, x} + {11'd0, x[17:10]};
        q0  = est[17:10];
        rem = x - (({10'd0, q0} << 10) - {10'd0, q0});
        q   = (rem >= 18'd1023) ? q0 + 8'd1 : q0;
        return q;
    endfunction

    assign w10_b = widen10(i_word[9:0]);
    assign w10_g = widen10(i_word[19:10]);
    assign w10_r = widen10(i_word[29:20]);

    always_comb begin
        r  = '0;
        g  = '0;
        b  = '0;
        a  = pp2rgba_pkg::CHAN_FULL;
        ok = 1'b1;
        case (i_fmt)
            pp2rgba_pkg::FMT_RGB888, pp2rgba_pkg::FMT_ARGB8888,
            pp2rgba_pkg::FMT_XRGB8888: begin
                b = b0;
                g = b1;
                r = b2;
                if (i_fmt == pp2rgba_pkg::FMT_ARGB8888) a = b3;
            end
            pp2rgba_pkg::FMT_ABGR8888, pp2rgba_pkg::FMT_XBGR8888: begin
                r = b0;
                g = b1;
                b = b2;
                if (i_fmt == pp2rgba_pkg::FMT_ABGR8888) a = b3;
            end
            pp2rgba_pkg::FMT_RGB565: begin
                r = {h[15:11], h[15:13]};
                g = {h[10:5], h[10:9]};
                b = {h[4:0], h[4:2]};
            end
            pp2rgba_pkg::FMT_ARGB1555, pp2rgba_pkg::FMT_XRGB1555: begin
                r = {h[14:10], h[14:12]};
                g = {h[9:5], h[9:7]};
                b = {h[4:0], h[4:2]};
                if (i_fmt == pp2rgba_pkg::FMT_ARGB1555 && !h[15]) a = '0;
            end
            pp2rgba_pkg::FMT_ARGB4444, pp2rgba_pkg::FMT_XRGB4444: begin
                r = {h[11:8], h[11:8]};
                g = {h[7:4], h[7:4]};
                b = {h[3:0], h[3:0]};
                if (i_fmt == pp2rgba_pkg::FMT_ARGB4444) a = {h[15:12], h[15:12]};
            end
            pp2rgba_pkg::FMT_RGB332, pp2rgba_pkg::FMT_ARGB8332: begin
                r = pp2rgba_pkg::widen3(b0[7:5]);
                g = pp2rgba_pkg::widen3(b0[4:2]);
                b = {4{b0[1:0]}};
                if (i_fmt == pp2rgba_pkg::FMT_ARGB8332) a = b1;
            end
            pp2rgba_pkg::FMT_ARGB2101010: begin
                b = w10_b;
                g = w10_g;
                r = w10_r;
                a = {4{i_word[31:30]}};
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_res.pad       = '0;
        o_res.valid_res = ok;
        o_res.alpha     = a;
        o_res.blue      = b;
        o_res.green     = g;
        o_res.red       = r;
    end

endmodule
